FILE: hdl/mlt_pkg.sv
`default_nettype none
package mlt_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int LINE_BITS = 16;

  localparam logic [3:0] KIND_RET = 4'd0;
  localparam logic [3:0] KIND_IDENT = 4'd1;
  localparam logic [3:0] KIND_INT = 4'd2;
  localparam logic [3:0] KIND_STRING = 4'd3;
  localparam logic [3:0] KIND_SEMI = 4'd4;
  localparam logic [3:0] KIND_LBRACE = 4'd5;
  localparam logic [3:0] KIND_RBRACE = 4'd6;
  localparam logic [3:0] KIND_EOF = 4'd7;
  localparam logic [3:0] KIND_UNTERM = 4'd8;
  localparam logic [3:0] KIND_BADCHAR = 4'd9;

  typedef struct packed {
    logic [3:0] kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0] line;
    logic [7:0] bad;
    logic last;
  } result_t;

  typedef struct packed {
    logic push0;
    logic push1;
    result_t r0;
    result_t r1;
  } step_t;

  function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] from,
                                                 input logic [OFFSET_BITS-1:0] to);
    span = (to > from) ? to - from : '0;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/mini_language_tokenizer_core.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   char_code, end_of_input
// out      output     out_valid / out_stall token_kind, token_start, token_length,
//                                           token_line, bad_char, last_in_run
//
// A request can be accepted in every cycle while not stalled; each one is lexed from
// an input register and yields zero, one or two results into a four-entry output queue.
// Each request is held in the input register and its results are written into the
// output queue, which drains one result per cycle while out_stall is low.
// The input stalls while the input register is full and the queue has fewer than two
// free entries. Reset is synchronous and returns the lexer to its initial state.
`default_nettype none
module mini_language_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       token_kind,
  output logic [15:0]      token_start,
  output logic [15:0]      token_length,
  output logic [15:0]      token_line,
  output logic [7:0]       bad_char,
  output logic             last_in_run
);
  import mlt_pkg::*;

  logic       stage_valid, stage_valid_next;
  logic [7:0] stage_char;
  logic       stage_end;
  logic       room, process, in_take, pop;
  step_t      step;
  result_t    head;

  assign process = stage_valid && room;
  assign in_stall = stage_valid && !room;
  assign in_take = in_valid && !in_stall;
  assign stage_valid_next = in_take || (stage_valid && !process);
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_char <= char_code;
      stage_end <= end_of_input;
    end
  end

  mlt_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .process      (process),
    .char_code    (stage_char),
    .end_of_input (stage_end),
    .step         (step)
  );

  mlt_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .room       (room)
  );

  assign token_kind = head.kind;
  assign token_start = 16'(32'(head.start));
  assign token_length = 16'(32'(head.len));
  assign token_line = 16'(32'(head.line));
  assign bad_char = head.bad;
  assign last_in_run = head.last;

endmodule
`default_nettype wire

FILE: hdl/mlt_lexer.sv
`default_nettype none
module mlt_lexer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           process,
  input  wire logic [7:0]     char_code,
  input  wire logic           end_of_input,
  output mlt_pkg::step_t      step
);
  import mlt_pkg::*;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_INT = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_HALT = 3'd4;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_SEMI = 8'h3b;
  localparam logic [7:0] CHAR_LBRACE = 8'h7b;
  localparam logic [7:0] CHAR_RBRACE = 8'h7d;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  logic [2:0]             lex_mode, lex_mode_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [1:0]             keyword_progress, keyword_progress_next;
  logic                   keyword_broken, keyword_broken_next;

  logic                   is_alpha, is_digit, is_space, end_eff, flush, have_tok;
  logic [OFFSET_BITS-1:0] pos_adv;
  logic [LINE_BITS-1:0]   line_inc;
  logic [7:0]             kw_char;
  result_t                word, tok;

  always_comb begin
    case (keyword_progress)
      2'd0: kw_char = "r";
      2'd1: kw_char = "e";
      2'd2: kw_char = "t";
      default: kw_char = CHAR_NUL;
    endcase
  end

  assign is_alpha = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z");
  assign is_digit = char_code >= "0" && char_code <= "9";
  assign is_space = char_code == " " || (char_code >= 8'd9 && char_code <= 8'd13);
  assign end_eff = end_of_input || char_code == CHAR_NUL;
  assign pos_adv = (byte_position != POS_MAX) ? byte_position + 1'b1 : byte_position;
  assign line_inc = (line_count != LINE_MAX) ? line_count + 1'b1 : line_count;

  always_comb begin
    word.kind = (lex_mode == MODE_INT) ? KIND_INT :
                ((!keyword_broken && keyword_progress == 2'd3) ? KIND_RET : KIND_IDENT);
    word.start = start_offset;
    word.len = span(start_offset, byte_position);
    word.line = line_count;
    word.bad = 8'd0;
    word.last = 1'b0;
  end

  always_comb begin
    lex_mode_next = lex_mode;
    start_offset_next = start_offset;
    byte_position_next = byte_position;
    line_count_next = line_count;
    keyword_progress_next = keyword_progress;
    keyword_broken_next = keyword_broken;
    step = '0;
    tok = '0;
    flush = 1'b0;
    have_tok = 1'b0;
    tok.start = byte_position;
    tok.len = OFFSET_BITS'(1);
    tok.line = line_count;
    if (process && lex_mode != MODE_HALT) begin
      if (end_eff) begin
        lex_mode_next = MODE_HALT;
        if (lex_mode == MODE_STRING) begin
          step.push0 = 1'b1;
          step.r0 = word;
          step.r0.kind = KIND_UNTERM;
        end else begin
          tok.kind = KIND_EOF;
          tok.len = '0;
          if (lex_mode == MODE_IDENT || lex_mode == MODE_INT) begin
            step.push0 = 1'b1;
            step.push1 = 1'b1;
            step.r0 = word;
            step.r1 = tok;
          end else begin
            step.push0 = 1'b1;
            step.r0 = tok;
          end
        end
      end else if (lex_mode == MODE_STRING) begin
        if (char_code == CHAR_QUOTE) begin
          step.push0 = 1'b1;
          step.r0 = word;
          step.r0.kind = KIND_STRING;
          step.r0.start = start_offset + 1'b1;
          step.r0.len = (word.len != '0) ? word.len - 1'b1 : word.len;
          lex_mode_next = MODE_IDLE;
        end else if (char_code == CHAR_LF) begin
          line_count_next = line_inc;
        end
        byte_position_next = pos_adv;
      end else if (lex_mode == MODE_IDENT && (is_alpha || is_digit)) begin
        if (!keyword_broken && keyword_progress != 2'd3 && char_code == kw_char) begin
          keyword_progress_next = keyword_progress + 1'b1;
        end else begin
          keyword_broken_next = 1'b1;
        end
        byte_position_next = pos_adv;
      end else if (lex_mode == MODE_INT && is_digit) begin
        byte_position_next = pos_adv;
      end else begin
        flush = lex_mode == MODE_IDENT || lex_mode == MODE_INT;
        lex_mode_next = MODE_IDLE;
        start_offset_next = byte_position;
        if (is_space) begin
          if (char_code == CHAR_LF) begin
            line_count_next = line_inc;
          end
        end else if (is_alpha) begin
          lex_mode_next = MODE_IDENT;
          keyword_progress_next = (char_code == "r") ? 2'd1 : 2'd0;
          keyword_broken_next = char_code != "r";
        end else if (is_digit) begin
          lex_mode_next = MODE_INT;
        end else if (char_code == CHAR_QUOTE) begin
          lex_mode_next = MODE_STRING;
        end else if (char_code == CHAR_SEMI) begin
          have_tok = 1'b1;
          tok.kind = KIND_SEMI;
        end else if (char_code == CHAR_LBRACE) begin
          have_tok = 1'b1;
          tok.kind = KIND_LBRACE;
        end else if (char_code == CHAR_RBRACE) begin
          have_tok = 1'b1;
          tok.kind = KIND_RBRACE;
        end else begin
          have_tok = 1'b1;
          tok.kind = KIND_BADCHAR;
          tok.bad = char_code;
          lex_mode_next = MODE_HALT;
        end
        if (flush) begin
          step.push0 = 1'b1;
          step.r0 = word;
          step.push1 = have_tok;
          step.r1 = tok;
        end else begin
          step.push0 = have_tok;
          step.r0 = tok;
        end
        byte_position_next = pos_adv;
      end
    end
    step.r0.last = step.push0 && !step.push1;
    step.r1.last = step.push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= MODE_IDLE;
      start_offset <= '0;
      byte_position <= '0;
      line_count <= LINE_BITS'(1);
      keyword_progress <= 2'd0;
      keyword_broken <= 1'b0;
    end else begin
      lex_mode <= lex_mode_next;
      start_offset <= start_offset_next;
      byte_position <= byte_position_next;
      line_count <= line_count_next;
      keyword_progress <= keyword_progress_next;
      keyword_broken <= keyword_broken_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mlt_outq.sv
`default_nettype none
module mlt_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mlt_pkg::step_t   step,
  input  wire logic             pop,
  output mlt_pkg::result_t      head,
  output logic                  head_valid,
  output logic                  room
);
  import mlt_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr, wr_ptr_next;
  logic [1:0] rd_ptr, rd_ptr_next;
  logic [2:0] count, count_next;

  assign head = mem[rd_ptr];
  assign head_valid = count != 3'd0;
  assign room = count <= 3'd2;

  assign wr_ptr_next = wr_ptr + 2'(step.push0) + 2'(step.push1);
  assign rd_ptr_next = rd_ptr + 2'(pop);
  assign count_next = count + 3'(step.push0) + 3'(step.push1) - 3'(pop);

  always_ff @(posedge clk) begin
    if (step.push0) begin
      mem[wr_ptr] <= step.r0;
    end
    if (step.push1) begin
      mem[wr_ptr + 2'd1] <= step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mlt_checker.sv
`default_nettype none
module mlt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  token_kind,
  input wire logic [15:0] token_start,
  input wire logic [15:0] token_length,
  input wire logic        last_in_run
);
  import mlt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(token_start)
                               && $stable(token_length) && $stable(last_in_run))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_kind <= KIND_BADCHAR)
    else $error("token kind out of range");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_EOF || token_kind == KIND_UNTERM ||
                  token_kind == KIND_BADCHAR) |-> last_in_run)
    else $error("terminal token not marked last");

  a_eof_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_EOF |-> token_length == 16'd0)
    else $error("eof token with nonzero length");

  a_punct_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_SEMI || token_kind == KIND_LBRACE ||
                  token_kind == KIND_RBRACE || token_kind == KIND_BADCHAR)
    |-> token_length == 16'd1 && last_in_run)
    else $error("single byte token malformed");

endmodule

bind mini_language_tokenizer_core mlt_checker u_mlt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .token_kind   (token_kind),
  .token_start  (token_start),
  .token_length (token_length),
  .last_in_run  (last_in_run)
);
`default_nettype wire
